[src/gps_coordinate_record_parser_defines.svh]
// assertion macros for the coordinate record parser
// used by the top level only, no other dependencies
`ifndef GPS_COORDINATE_RECORD_PARSER_DEFINES_SVH
`define GPS_COORDINATE_RECORD_PARSER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define GCRP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define GCRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/gcrp_pkg.sv]
// shared types, constants and helper functions of the coordinate record parser
// no dependencies
package gcrp_pkg;

   localparam int FIELD_LENGTH_DEFAULT = 16;
   localparam int FRAC_DIGITS_DEFAULT  = 6;

   localparam int VALUE_WIDTH     = 35;
   localparam int INT_ACC_WIDTH   = 40;
   localparam int CHAR_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 8;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAT_LOW  = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAT_HIGH = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LON_LOW  = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LON_HIGH = 8'd3;

   localparam logic [VALUE_WIDTH-1:0] LAT_LOW_RESET  = 35'd0;
   localparam logic [VALUE_WIDTH-1:0] LAT_HIGH_RESET = 35'd9000000000;
   localparam logic [VALUE_WIDTH-1:0] LON_LOW_RESET  = 35'd0;
   localparam logic [VALUE_WIDTH-1:0] LON_HIGH_RESET = 35'd18000000000;

   // record characters
   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [CHAR_WIDTH-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_N     = 8'h4E;
   localparam logic [CHAR_WIDTH-1:0] CHAR_S     = 8'h53;
   localparam logic [CHAR_WIDTH-1:0] CHAR_E     = 8'h45;
   localparam logic [CHAR_WIDTH-1:0] CHAR_W     = 8'h57;

   typedef enum logic [7:0] {
      PH_LAT_INT  = 8'b0000_0001,
      PH_LAT_FRAC = 8'b0000_0010,
      PH_LAT_DIR  = 8'b0000_0100,
      PH_LAT_GAP  = 8'b0000_1000,
      PH_LON_INT  = 8'b0001_0000,
      PH_LON_FRAC = 8'b0010_0000,
      PH_LON_DIR  = 8'b0100_0000,
      PH_DONE     = 8'b1000_0000
   } phase_type;

   // power of ten, for elaboration-time constants
   function automatic longint unsigned pow10(input int n);
      longint unsigned p;
      p = 64'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

endpackage

[src/gcrp_field_value.sv]
// field value assembly and range check: integer part plus fraction, inclusive limits
// depends on gcrp_pkg
module gcrp_field_value #(
   parameter int FRAC_DIGITS = gcrp_pkg::FRAC_DIGITS_DEFAULT
) (
   input  logic                                   int_big,
   input  logic [gcrp_pkg::VALUE_WIDTH-1:0]       int_scaled,
   input  logic [$clog2(gcrp_pkg::pow10(FRAC_DIGITS))-1:0] frac_value,
   input  logic [gcrp_pkg::VALUE_WIDTH-1:0]       low_limit,
   input  logic [gcrp_pkg::VALUE_WIDTH-1:0]       high_limit,
   output logic [gcrp_pkg::VALUE_WIDTH-1:0]       value
);
   import gcrp_pkg::*;

   logic [VALUE_WIDTH:0] sum;
   logic                 in_range;

   // scaled integer is below 2^35 unless int_big, so the sum fits one extra bit
   assign sum      = {1'b0, int_scaled} + (VALUE_WIDTH + 1)'(frac_value);
   assign in_range = !int_big
                     && (sum >= {1'b0, low_limit})
                     && (sum <= {1'b0, high_limit});
   assign value    = in_range ? sum[VALUE_WIDTH-1:0] : '0;

endmodule

[src/gps_coordinate_record_parser.sv]
// top level of the coordinate record parser: input register, byte parser, result register
// depends on gcrp_pkg, gcrp_field_value and gps_coordinate_record_parser_defines.svh
`include "gps_coordinate_record_parser_defines.svh"

// Parses a "latitude,N|S,longitude,E|W" record one byte per beat and returns one
// result beat (both magnitudes and both direction flags) on the longitude direction
// byte. Rate: one byte per clock while the result channel keeps up, as the digit
// update (times ten plus digit weight, then a compare against 2^35) is combinational.
// A byte is captured in the input register when it is accepted and parsed from there;
// the parse of the direction byte loads the result beat into the result register.
// The result register frees the input side while the result channel keeps up: a
// byte can be taken in every cycle. While a finished result waits under a stall, the
// input register still takes one byte, then holds it and stalls the byte channel
// until the result beat is taken. Magnitudes are in units of 10^-FRAC_DIGITS;
// values outside the inclusive limit registers read as zero. A record_start beat
// restarts the parse but keeps flags and limits. The user must write the limit
// registers only while the block is idle; the block itself does not enforce this.
module gps_coordinate_record_parser #(
   parameter int FIELD_LENGTH = gcrp_pkg::FIELD_LENGTH_DEFAULT,
   parameter int FRAC_DIGITS  = gcrp_pkg::FRAC_DIGITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // byte channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [gcrp_pkg::CHAR_WIDTH-1:0]       req_char_in,
   input  logic                                  req_record_start,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [gcrp_pkg::VALUE_WIDTH-1:0]      rsp_lat_value,
   output logic                                  rsp_lat_south,
   output logic [gcrp_pkg::VALUE_WIDTH-1:0]      rsp_lon_value,
   output logic                                  rsp_lon_west,
   // limit register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gcrp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [gcrp_pkg::VALUE_WIDTH-1:0]      csr_wdata
);
   import gcrp_pkg::*;

   localparam int POS_WIDTH  = $clog2(FIELD_LENGTH + 1);
   localparam int CNT_WIDTH  = $clog2(FRAC_DIGITS + 1);
   localparam int FRAC_WIDTH = $clog2(pow10(FRAC_DIGITS));
   localparam longint unsigned INT_WEIGHT = pow10(FRAC_DIGITS);

   // limit registers
   logic [VALUE_WIDTH-1:0] lat_low_ff,  lat_high_ff,  lon_low_ff,  lon_high_ff;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [CHAR_WIDTH-1:0] in_char_ff;
   logic                  in_start_ff;

   // parse state
   phase_type              phase_ff, phase_in;
   logic [POS_WIDTH-1:0]   field_pos_ff, field_pos_in;
   logic                   seen_ff, seen_in;
   logic                   invalid_ff, invalid_in;
   logic                   big_ff, big_in;
   logic [VALUE_WIDTH-1:0] scaled_ff, scaled_in;
   logic [FRAC_WIDTH-1:0]  frac_ff, frac_in;
   logic [CNT_WIDTH-1:0]   frac_cnt_ff, frac_cnt_in;
   logic [VALUE_WIDTH-1:0] held_ff, held_in;
   logic                   south_ff, south_in;
   logic                   west_ff, west_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_lat_value_ff, rsp_lon_value_ff;
   logic                   rsp_lat_south_ff, rsp_lon_west_ff;

   // handshake
   logic out_blocked, step_fire, req_accept, result_fire;

   // state after an optional restart
   phase_type              phase_cur;
   logic [POS_WIDTH-1:0]   pos_cur;
   logic                   seen_cur, invalid_cur, big_cur;
   logic [VALUE_WIDTH-1:0] scaled_cur;
   logic [FRAC_WIDTH-1:0]  frac_cur;
   logic [CNT_WIDTH-1:0]   cnt_cur;

   // number byte results
   phase_type              nb_phase;
   logic                   nb_seen, nb_invalid, nb_big;
   logic [VALUE_WIDTH-1:0] nb_scaled;
   logic [FRAC_WIDTH-1:0]  nb_frac;
   logic [CNT_WIDTH-1:0]   nb_cnt;

   logic                     is_digit, frac_phase, field_end;
   logic [3:0]               digit, int_digit, frac_digit;
   logic [INT_ACC_WIDTH-1:0] int_wide, int_sum;
   logic [FRAC_WIDTH+3:0]    frac_sum;
   logic [FRAC_WIDTH-1:0]    frac_weight [FRAC_DIGITS+1];

   logic [VALUE_WIDTH-1:0] sel_low, sel_high, field_val;

   // ------------------------------------------------------------------
   // handshake: the input register drains whenever the result slot can take a beat
   // ------------------------------------------------------------------
   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign step_fire   = in_valid_ff && !out_blocked;
   assign req_stall   = in_valid_ff && out_blocked;
   assign req_accept  = req_valid && !req_stall;
   assign csr_ready   = 1'b1;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // fraction digit weights: 10^(FRAC_DIGITS-1-k) for digit k, zero past the end
   // ------------------------------------------------------------------
   for (genvar i = 0; i <= FRAC_DIGITS; i++) begin : g_weight
      if (i < FRAC_DIGITS) begin : g_used
         assign frac_weight[i] = FRAC_WIDTH'(pow10(FRAC_DIGITS - 1 - i));
      end else begin : g_end
         assign frac_weight[i] = '0;
      end
   end

   // ------------------------------------------------------------------
   // restart on record_start
   // ------------------------------------------------------------------
   always_comb begin
      if (in_start_ff) begin
         phase_cur   = PH_LAT_INT;
         pos_cur     = '0;
         seen_cur    = 1'b0;
         invalid_cur = 1'b0;
         big_cur     = 1'b0;
         scaled_cur  = '0;
         frac_cur    = '0;
         cnt_cur     = '0;
      end else begin
         phase_cur   = phase_ff;
         pos_cur     = field_pos_ff;
         seen_cur    = seen_ff;
         invalid_cur = invalid_ff;
         big_cur     = big_ff;
         scaled_cur  = scaled_ff;
         frac_cur    = frac_ff;
         cnt_cur     = frac_cnt_ff;
      end
   end

   // ------------------------------------------------------------------
   // one number byte: integer digit (times ten plus weight) or fraction digit
   // ------------------------------------------------------------------
   assign is_digit   = (in_char_ff >= CHAR_ZERO) && (in_char_ff <= CHAR_NINE);
   assign digit      = 4'(in_char_ff - CHAR_ZERO);
   assign int_digit  = (is_digit && !invalid_cur) ? digit : 4'd0;
   assign frac_digit = is_digit ? digit : 4'd0;
   assign frac_phase = (phase_cur == PH_LAT_FRAC) || (phase_cur == PH_LON_FRAC);
   assign field_end  = (pos_cur >= POS_WIDTH'(FIELD_LENGTH)) || (in_char_ff == CHAR_COMMA);

   // scaled integer is int * 10^FRAC_DIGITS; beyond 2^35 it can never pass a limit
   assign int_wide = INT_ACC_WIDTH'(scaled_cur);
   assign int_sum  = (int_wide << 3) + (int_wide << 1)
                     + INT_ACC_WIDTH'(int_digit) * INT_ACC_WIDTH'(INT_WEIGHT);
   assign frac_sum = (FRAC_WIDTH + 4)'(frac_cur)
                     + (FRAC_WIDTH + 4)'(frac_digit) * (FRAC_WIDTH + 4)'(frac_weight[cnt_cur]);

   always_comb begin
      nb_phase   = phase_cur;
      nb_seen    = seen_cur;
      nb_invalid = invalid_cur;
      nb_big     = big_cur;
      nb_scaled  = scaled_cur;
      nb_frac    = frac_cur;
      nb_cnt     = cnt_cur;
      if (!frac_phase) begin
         if (!seen_cur && (in_char_ff == CHAR_NUL)) begin
            // leading nul skipped, still counts toward the field length
         end else if (in_char_ff == CHAR_DOT) begin
            nb_seen  = 1'b1;
            nb_phase = (phase_cur == PH_LAT_INT) ? PH_LAT_FRAC : PH_LON_FRAC;
         end else begin
            nb_seen = 1'b1;
            if (!is_digit) begin
               nb_invalid = 1'b1;
            end
            if (!big_cur) begin
               if (int_sum[INT_ACC_WIDTH-1:VALUE_WIDTH] != '0) begin
                  nb_big = 1'b1;
               end else begin
                  nb_scaled = int_sum[VALUE_WIDTH-1:0];
               end
            end
         end
      end else begin
         if (in_char_ff == CHAR_NUL) begin
            // nul closes the fraction
            nb_cnt = CNT_WIDTH'(FRAC_DIGITS);
         end else if (cnt_cur < CNT_WIDTH'(FRAC_DIGITS)) begin
            nb_frac = frac_sum[FRAC_WIDTH-1:0];
            nb_cnt  = cnt_cur + CNT_WIDTH'(1);
         end
      end
   end

   // ------------------------------------------------------------------
   // field value, shared by the latitude separator and the longitude direction byte
   // ------------------------------------------------------------------
   assign sel_low  = (phase_cur == PH_LON_DIR) ? lon_low_ff  : lat_low_ff;
   assign sel_high = (phase_cur == PH_LON_DIR) ? lon_high_ff : lat_high_ff;

   gcrp_field_value #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_field_value (
      .int_big    (big_cur),
      .int_scaled (scaled_cur),
      .frac_value (frac_cur),
      .low_limit  (sel_low),
      .high_limit (sel_high),
      .value      (field_val)
   );

   // ------------------------------------------------------------------
   // record sequencer
   // ------------------------------------------------------------------
   always_comb begin
      phase_in     = phase_ff;
      field_pos_in = field_pos_ff;
      seen_in      = seen_ff;
      invalid_in   = invalid_ff;
      big_in       = big_ff;
      scaled_in    = scaled_ff;
      frac_in      = frac_ff;
      frac_cnt_in  = frac_cnt_ff;
      held_in      = held_ff;
      south_in     = south_ff;
      west_in      = west_ff;
      result_fire  = 1'b0;
      if (step_fire) begin
         phase_in     = phase_cur;
         field_pos_in = pos_cur;
         seen_in      = seen_cur;
         invalid_in   = invalid_cur;
         big_in       = big_cur;
         scaled_in    = scaled_cur;
         frac_in      = frac_cur;
         frac_cnt_in  = cnt_cur;
         unique case (phase_cur) inside
            PH_LAT_INT, PH_LAT_FRAC: begin
               if (field_end) begin
                  held_in      = field_val;
                  phase_in     = PH_LAT_DIR;
                  field_pos_in = '0;
                  seen_in      = 1'b0;
                  invalid_in   = 1'b0;
                  big_in       = 1'b0;
                  scaled_in    = '0;
                  frac_in      = '0;
                  frac_cnt_in  = '0;
               end else begin
                  phase_in     = nb_phase;
                  field_pos_in = pos_cur + POS_WIDTH'(1);
                  seen_in      = nb_seen;
                  invalid_in   = nb_invalid;
                  big_in       = nb_big;
                  scaled_in    = nb_scaled;
                  frac_in      = nb_frac;
                  frac_cnt_in  = nb_cnt;
               end
            end
            PH_LAT_DIR: begin
               if (in_char_ff == CHAR_N) begin
                  south_in = 1'b0;
               end else if (in_char_ff == CHAR_S) begin
                  south_in = 1'b1;
               end
               phase_in = PH_LAT_GAP;
            end
            PH_LAT_GAP: begin
               // byte after the latitude direction is dropped
               phase_in = PH_LON_INT;
            end
            PH_LON_INT, PH_LON_FRAC: begin
               if (field_end) begin
                  // longitude field kept as is until the direction byte
                  phase_in = PH_LON_DIR;
               end else begin
                  phase_in     = nb_phase;
                  field_pos_in = pos_cur + POS_WIDTH'(1);
                  seen_in      = nb_seen;
                  invalid_in   = nb_invalid;
                  big_in       = nb_big;
                  scaled_in    = nb_scaled;
                  frac_in      = nb_frac;
                  frac_cnt_in  = nb_cnt;
               end
            end
            PH_LON_DIR: begin
               if (in_char_ff == CHAR_E) begin
                  west_in = 1'b0;
               end else if (in_char_ff == CHAR_W) begin
                  west_in = 1'b1;
               end
               result_fire = 1'b1;
               phase_in    = PH_DONE;
            end
            PH_DONE: begin
               // idle until the next record_start
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (result_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_LAT_INT;
         field_pos_ff <= '0;
         seen_ff      <= 1'b0;
         invalid_ff   <= 1'b0;
         big_ff       <= 1'b0;
         scaled_ff    <= '0;
         frac_ff      <= '0;
         frac_cnt_ff  <= '0;
         held_ff      <= '0;
         south_ff     <= 1'b0;
         west_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         field_pos_ff <= field_pos_in;
         seen_ff      <= seen_in;
         invalid_ff   <= invalid_in;
         big_ff       <= big_in;
         scaled_ff    <= scaled_in;
         frac_ff      <= frac_in;
         frac_cnt_ff  <= frac_cnt_in;
         held_ff      <= held_in;
         south_ff     <= south_in;
         west_ff      <= west_in;
      end
   end

   // limit registers, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_low_ff  <= LAT_LOW_RESET;
         lat_high_ff <= LAT_HIGH_RESET;
         lon_low_ff  <= LON_LOW_RESET;
         lon_high_ff <= LON_HIGH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LAT_LOW:  lat_low_ff  <= csr_wdata;
            CSR_LAT_HIGH: lat_high_ff <= csr_wdata;
            CSR_LON_LOW:  lon_low_ff  <= csr_wdata;
            CSR_LON_HIGH: lon_high_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff  <= req_char_in;
         in_start_ff <= req_record_start;
      end
      if (result_fire) begin
         rsp_lat_value_ff <= held_ff;
         rsp_lat_south_ff <= south_ff;
         rsp_lon_value_ff <= field_val;
         rsp_lon_west_ff  <= west_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lat_value = rsp_lat_value_ff;
   assign rsp_lat_south = rsp_lat_south_ff;
   assign rsp_lon_value = rsp_lon_value_ff;
   assign rsp_lon_west  = rsp_lon_west_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `GCRP_ASSERT_NEXT(a_result_loaded, clock, reset, result_fire, rsp_valid_ff, "result beat lost")
   `GCRP_ASSERT_NEXT(a_input_held, clock, reset, in_valid_ff && !step_fire, in_valid_ff && $stable(in_char_ff), "held byte overwritten")
   `GCRP_ASSERT_SAME(a_pos_bound, clock, reset, 1'b1, field_pos_ff <= POS_WIDTH'(FIELD_LENGTH), "field position past length")
   `GCRP_ASSERT_SAME(a_frac_bound, clock, reset, 1'b1, frac_cnt_ff <= CNT_WIDTH'(FRAC_DIGITS), "too many fraction digits")

endmodule
